>>> src/vrhp_pkg.sv
package vrhp_pkg;

  // field widths
  localparam int PIX_W     = 16;
  localparam int OUT_W     = 24;
  localparam int ALPHA_W   = 15;
  localparam int DIM_W     = 11;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 15;

  // row counter: frames hold at most ROW_LIMIT rows
  localparam int ROW_LIMIT = 1024;
  localparam int ROW_W     = $clog2(ROW_LIMIT);

  // datapath widths: exact sum and full product
  localparam int SUM_W   = OUT_W + 1;
  localparam int PROD_W  = SUM_W + ALPHA_W + 1;
  localparam int FRAC_SH = 15;
  localparam int RND_W   = PROD_W - FRAC_SH;

  localparam logic signed [OUT_W-1:0]  BORDER_VALUE = OUT_W'(256);
  localparam logic signed [OUT_W-1:0]  OUT_MAX      = {1'b0, {(OUT_W-1){1'b1}}};
  localparam logic signed [OUT_W-1:0]  OUT_MIN      = {1'b1, {(OUT_W-1){1'b0}}};
  localparam logic signed [PROD_W-1:0] ROUND_HALF   = PROD_W'(1 << (FRAC_SH - 1));

  // parameter defaults
  localparam int DEF_MAX_WIDTH   = 1024;
  localparam int DEF_BORDER_ROWS = 2;

  // register reset values
  localparam logic [ALPHA_W-1:0] ALPHA_RST = ALPHA_W'(32767);
  localparam logic [DIM_W-1:0]   WIDTH_RST = DIM_W'(512);
  localparam logic [DIM_W-1:0]   COUNT_RST = DIM_W'(512);

  // register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ALPHA = 2'd0,
    CFG_WIDTH = 2'd1,
    CFG_COUNT = 2'd2
  } cfg_idx_t;

  // per-pixel flags from the raster tracker
  typedef struct packed {
    logic win;
    logic last;
  } pos_flags_t;

endpackage

>>> src/vrhp_raster.sv
module vrhp_raster import vrhp_pkg::*; #(
  parameter int MAX_WIDTH   = DEF_MAX_WIDTH,
  parameter int BORDER_ROWS = DEF_BORDER_ROWS
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic [DIM_W-1:0]               row_width,
  input  logic [DIM_W-1:0]               row_count,
  input  logic                           advance,
  output logic [$clog2(MAX_WIDTH)-1:0]   col,
  output pos_flags_t                     flags
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RC_W = DIM_W + 1;

  logic [CW-1:0]    col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic [31:0]      w_full;
  logic [CW:0]      w_eff;
  logic [DIM_W-1:0] rc_eff;
  logic [RC_W-1:0]  row_top;
  logic [RC_W-1:0]  rc_even;
  logic             row_end, frame_end;

  // effective geometry: zero acts as one, large values clip
  always_comb begin
    if (row_width == '0) begin
      w_full = 32'd1;
    end else if (32'(row_width) > 32'(MAX_WIDTH)) begin
      w_full = 32'(MAX_WIDTH);
    end else begin
      w_full = 32'(row_width);
    end
    w_eff = w_full[CW:0];
    if (row_count == '0) begin
      rc_eff = DIM_W'(1);
    end else if (row_count > DIM_W'(ROW_LIMIT)) begin
      rc_eff = DIM_W'(ROW_LIMIT);
    end else begin
      rc_eff = row_count;
    end
  end

  // filter window and end of row / frame
  assign row_top   = RC_W'(row_r) + RC_W'(BORDER_ROWS + 1);
  assign rc_even   = {1'b0, rc_eff[DIM_W-1:1], 1'b0};
  assign row_end   = ((CW+1)'(col_r) + (CW+1)'(1)) >= w_eff;
  assign frame_end = row_end && ((DIM_W'(row_r) + DIM_W'(1)) >= rc_eff);

  assign col        = col_r;
  assign flags.win  = (RC_W'(row_r) >= RC_W'(BORDER_ROWS)) && (row_top <= rc_even) &&
                      ((CW+1)'(col_r) < {w_eff[CW:1], 1'b0});
  assign flags.last = frame_end;

  // raster position update
  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (advance) begin
      if (row_end) begin
        col_nxt = '0;
        row_nxt = frame_end ? '0 : row_r + ROW_W'(1);
      end else begin
        col_nxt = col_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

endmodule

>>> src/vrhp_linebuf.sv
module vrhp_linebuf import vrhp_pkg::*; #(
  parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
  input  logic                         clk,
  input  logic                         rd_en,
  input  logic [$clog2(MAX_WIDTH)-1:0] rd_addr,
  output logic signed [PIX_W-1:0]      rd_in,
  output logic signed [OUT_W-1:0]      rd_out,
  input  logic                         wr_en,
  input  logic [$clog2(MAX_WIDTH)-1:0] wr_addr,
  input  logic signed [PIX_W-1:0]      wr_in,
  input  logic signed [OUT_W-1:0]      wr_out
);

  logic signed [PIX_W-1:0] in_mem [MAX_WIDTH];
  logic signed [OUT_W-1:0] out_mem [MAX_WIDTH];
  logic signed [PIX_W-1:0] rd_in_r;
  logic signed [OUT_W-1:0] rd_out_r;

  // previous row inputs and outputs, one write and one read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      in_mem[wr_addr]  <= wr_in;
      out_mem[wr_addr] <= wr_out;
    end
    if (rd_en) begin
      rd_in_r  <= in_mem[rd_addr];
      rd_out_r <= out_mem[rd_addr];
    end
  end

  assign rd_in  = rd_in_r;
  assign rd_out = rd_out_r;

endmodule

>>> src/vrhp_pipe.sv
module vrhp_pipe import vrhp_pkg::*; #(
  parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [ALPHA_W-1:0]           alpha_q15,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [PIX_W-1:0]      in_pix,
  input  logic [$clog2(MAX_WIDTH)-1:0] in_col,
  input  pos_flags_t                   in_flags,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [OUT_W-1:0]      out_data,
  output logic                         out_sat,
  output logic                         out_last
);

  localparam int CW = $clog2(MAX_WIDTH);

  // stage registers
  logic                     v1_r, v2_r, v3_r, v4_r;
  logic [CW-1:0]            col1_r, col2_r, col3_r;
  logic signed [PIX_W-1:0]  pix1_r, pix2_r, pix3_r;
  pos_flags_t               fl1_r, fl2_r, fl3_r;
  logic signed [SUM_W-1:0]  sum2_r;
  logic signed [PROD_W-1:0] prod3_r;
  logic signed [OUT_W-1:0]  res4_r;
  logic                     sat4_r, last4_r;

  logic                     en1, en2, en3, en4;
  logic                     hazard, accept;
  logic signed [PIX_W-1:0]  above_in;
  logic signed [OUT_W-1:0]  above_out;
  logic signed [SUM_W-1:0]  sum_nxt;
  logic signed [ALPHA_W:0]  alpha_s;
  logic signed [PROD_W-1:0] prod_nxt;
  logic signed [PROD_W-1:0] rnd;
  logic signed [RND_W-1:0]  scaled;
  logic signed [OUT_W-1:0]  res_nxt;
  logic                     sat_nxt;
  logic                     clip;

  // stage enables: a stage moves when empty or when its successor moves
  assign en4 = !v4_r || out_ready;
  assign en3 = !v3_r || en4;
  assign en2 = !v2_r || en3;
  assign en1 = !v1_r || en2;

  // a column still in flight has not written its line buffer entry yet
  assign hazard = (v1_r && (col1_r == in_col)) ||
                  (v2_r && (col2_r == in_col)) ||
                  (v3_r && (col3_r == in_col));
  assign in_ready = en1 && !hazard;
  assign accept   = in_valid && in_ready;

  vrhp_linebuf #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_linebuf (
    .clk     (clk),
    .rd_en   (en1),
    .rd_addr (in_col),
    .rd_in   (above_in),
    .rd_out  (above_out),
    .wr_en   (v3_r && en4),
    .wr_addr (col3_r),
    .wr_in   (pix3_r),
    .wr_out  (res_nxt)
  );

  // stage 2 input: exact difference sum
  assign sum_nxt = SUM_W'(above_out) + SUM_W'(pix1_r) - SUM_W'(above_in);

  // stage 3 input: coefficient multiply
  assign alpha_s  = {1'b0, alpha_q15};
  assign prod_nxt = PROD_W'(alpha_s * sum2_r);

  // output stage input: round half up, floor shift, clip
  always_comb begin
    rnd    = prod3_r + ROUND_HALF;
    scaled = rnd[PROD_W-1:FRAC_SH];
    clip   = (scaled[RND_W-1:OUT_W-1] != '0) && (scaled[RND_W-1:OUT_W-1] != '1);
    if (!fl3_r.win) begin
      res_nxt = BORDER_VALUE;
      sat_nxt = 1'b0;
    end else if (clip) begin
      res_nxt = scaled[RND_W-1] ? OUT_MIN : OUT_MAX;
      sat_nxt = 1'b1;
    end else begin
      res_nxt = scaled[OUT_W-1:0];
      sat_nxt = 1'b0;
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (en1) v1_r <= accept;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
      if (en4) v4_r <= v3_r;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (en1) begin
      col1_r <= in_col;
      pix1_r <= in_pix;
      fl1_r  <= in_flags;
    end
    if (en2) begin
      col2_r <= col1_r;
      pix2_r <= pix1_r;
      fl2_r  <= fl1_r;
      sum2_r <= sum_nxt;
    end
    if (en3) begin
      col3_r  <= col2_r;
      pix3_r  <= pix2_r;
      fl3_r   <= fl2_r;
      prod3_r <= prod_nxt;
    end
    if (en4) begin
      res4_r  <= res_nxt;
      sat4_r  <= sat_nxt;
      last4_r <= fl3_r.last;
    end
  end

  assign out_valid = v4_r;
  assign out_data  = res4_r;
  assign out_sat   = sat4_r;
  assign out_last  = last4_r;

endmodule

>>> src/vertical_rc_highpass_image.sv
// path: stage 1, 2 and 3 registers, then the output register holding the result
// throughput: one pixel per cycle when the row is 4 or more pixels wide and the output
// is not stalled; narrower rows wait for the same column's line buffer write
// reset: synchronous active low, clears position, valid bits and configuration registers
// to defaults; stage payloads and line buffer contents stay undefined until written
module vertical_rc_highpass_image import vrhp_pkg::*; #(
  parameter int MAX_WIDTH   = DEF_MAX_WIDTH,
  parameter int BORDER_ROWS = DEF_BORDER_ROWS
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_idx,
  input  logic [CFG_DAT_W-1:0]   cfg_wdata,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic signed [PIX_W-1:0] in_pixel_in,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic signed [OUT_W-1:0] out_filtered_out,
  output logic                   out_saturated,
  output logic                   out_frame_last
);

  localparam int CW = $clog2(MAX_WIDTH);

  logic [ALPHA_W-1:0] alpha_r;
  logic [DIM_W-1:0]   width_r;
  logic [DIM_W-1:0]   count_r;
  logic [CW-1:0]      col;
  pos_flags_t         flags;
  logic               accept;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_r <= ALPHA_RST;
      width_r <= WIDTH_RST;
      count_r <= COUNT_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_idx))
        CFG_ALPHA: alpha_r <= cfg_wdata[ALPHA_W-1:0];
        CFG_WIDTH: width_r <= cfg_wdata[DIM_W-1:0];
        CFG_COUNT: count_r <= cfg_wdata[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  assign accept = in_valid && in_ready;

  vrhp_raster #(
    .MAX_WIDTH   (MAX_WIDTH),
    .BORDER_ROWS (BORDER_ROWS)
  ) u_raster (
    .clk       (clk),
    .rst_n     (rst_n),
    .row_width (width_r),
    .row_count (count_r),
    .advance   (accept),
    .col       (col),
    .flags     (flags)
  );

  vrhp_pipe #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_pipe (
    .clk       (clk),
    .rst_n     (rst_n),
    .alpha_q15 (alpha_r),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_pix    (in_pixel_in),
    .in_col    (col),
    .in_flags  (flags),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_filtered_out),
    .out_sat   (out_saturated),
    .out_last  (out_frame_last)
  );

endmodule
